[src/kpc_pkg.sv]
// Shared types, constants and a helper function for the key press classifier.
`timescale 1ns / 1ps

package kpc_pkg;

  localparam int TICK_W  = 8;
  localparam int LIMIT_W = 15;
  localparam int TIMER_W = 16;
  localparam int INDEX_W = 3;
  localparam int WDATA_W = 15;

  localparam logic [INDEX_W-1:0] REG_TICK_MS       = 3'd0;
  localparam logic [INDEX_W-1:0] REG_LONG_MS       = 3'd1;
  localparam logic [INDEX_W-1:0] REG_SHORT_MS      = 3'd2;
  localparam logic [INDEX_W-1:0] REG_DOUBLE_MS     = 3'd3;
  localparam logic [INDEX_W-1:0] REG_LONG_ENABLE   = 3'd4;
  localparam logic [INDEX_W-1:0] REG_DOUBLE_ENABLE = 3'd5;

  localparam logic [TICK_W-1:0]  TICK_MS_RST   = 8'd20;
  localparam logic [LIMIT_W-1:0] LONG_MS_RST   = 15'd800;
  localparam logic [LIMIT_W-1:0] SHORT_MS_RST  = 15'd200;
  localparam logic [LIMIT_W-1:0] DOUBLE_MS_RST = 15'd200;

  localparam logic [1:0] CODE_NONE   = 2'd0;
  localparam logic [1:0] CODE_SHORT  = 2'd1;
  localparam logic [1:0] CODE_LONG   = 2'd2;
  localparam logic [1:0] CODE_DOUBLE = 2'd3;

  typedef struct packed {
    logic [TICK_W-1:0]  tick_ms;
    logic [LIMIT_W-1:0] long_ms;
    logic [LIMIT_W-1:0] short_ms;
    logic [LIMIT_W-1:0] double_ms;
    logic               long_enable;
    logic               double_enable;
  } cfg_t;

  // Timers saturate at their full-scale value instead of wrapping.
  function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] t,
                                                 input logic [TICK_W-1:0] d);
    logic [TIMER_W:0] s;
    s = {1'b0, t} + {{(TIMER_W+1-TICK_W){1'b0}}, d};
    sat_add = s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
  endfunction

endpackage

[src/key_press_classifier_core.sv]
// Top level of the key press classifier: input register, rule logic and result register.
// A word waits in the input register and is classified into the result register once it frees.
// Throughput: one word per cycle while out_ready is high; input refills as the result drains.
// The result register frees up whenever out_ready is high, so stalls pass back without bubbles.
// Sync active-low reset restores config defaults and clears valid flags and classifier state.
`timescale 1ns / 1ps

module key_press_classifier_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_pressed,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_event_code,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [kpc_pkg::INDEX_W-1:0] cfg_index,
  input  logic [kpc_pkg::WDATA_W-1:0] cfg_wdata
);

  kpc_pkg::cfg_t cfg;
  logic          in_valid_r;
  logic          in_pressed_r;
  logic          out_valid_r;
  logic [1:0]    out_code_r;
  logic [1:0]    code;
  logic          advance;

  assign cfg_ready = 1'b1;

  kpc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  kpc_classify u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .pressed    (in_pressed_r),
    .cfg        (cfg),
    .event_code (code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_pressed_r <= in_pressed;
    end
    if (advance) begin
      out_code_r <= code;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_code = out_code_r;

endmodule

[src/kpc_cfg_regs.sv]
// Configuration register file for timing limits and feature enables.
`timescale 1ns / 1ps

module kpc_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [kpc_pkg::INDEX_W-1:0] wr_index,
  input  logic [kpc_pkg::WDATA_W-1:0] wr_data,
  output kpc_pkg::cfg_t              cfg
);

  kpc_pkg::cfg_t cfg_r;
  kpc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        kpc_pkg::REG_TICK_MS:       cfg_nxt.tick_ms = wr_data[kpc_pkg::TICK_W-1:0];
        kpc_pkg::REG_LONG_MS:       cfg_nxt.long_ms = wr_data[kpc_pkg::LIMIT_W-1:0];
        kpc_pkg::REG_SHORT_MS:      cfg_nxt.short_ms = wr_data[kpc_pkg::LIMIT_W-1:0];
        kpc_pkg::REG_DOUBLE_MS:     cfg_nxt.double_ms = wr_data[kpc_pkg::LIMIT_W-1:0];
        kpc_pkg::REG_LONG_ENABLE:   cfg_nxt.long_enable = wr_data[0];
        kpc_pkg::REG_DOUBLE_ENABLE: cfg_nxt.double_enable = wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_ms       <= kpc_pkg::TICK_MS_RST;
      cfg_r.long_ms       <= kpc_pkg::LONG_MS_RST;
      cfg_r.short_ms      <= kpc_pkg::SHORT_MS_RST;
      cfg_r.double_ms     <= kpc_pkg::DOUBLE_MS_RST;
      cfg_r.long_enable   <= 1'b1;
      cfg_r.double_enable <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[src/kpc_classify.sv]
// Press classification rules with the level, hold timer, gap timer and first-press state.
`timescale 1ns / 1ps

module kpc_classify (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          pressed,
  input  kpc_pkg::cfg_t cfg,
  output logic [1:0]    event_code
);

  logic                        level_r;
  logic                        level_nxt;
  logic [kpc_pkg::TIMER_W-1:0] hold_r;
  logic [kpc_pkg::TIMER_W-1:0] hold_nxt;
  logic [kpc_pkg::TIMER_W-1:0] gap_r;
  logic [kpc_pkg::TIMER_W-1:0] gap_nxt;
  logic                        first_r;
  logic                        first_nxt;

  logic [kpc_pkg::TIMER_W-1:0] hold_a;
  logic [kpc_pkg::TIMER_W-1:0] gap_a;
  logic [kpc_pkg::TIMER_W-1:0] short_lim;
  logic [kpc_pkg::TIMER_W-1:0] long_lim;
  logic [kpc_pkg::TIMER_W-1:0] double_lim;
  logic                        first_a;
  logic                        long_hit;
  logic [1:0]                  code;

  assign short_lim  = {1'b0, cfg.short_ms};
  assign long_lim   = {1'b0, cfg.long_ms};
  assign double_lim = {1'b0, cfg.double_ms};

  always_comb begin
    code      = kpc_pkg::CODE_NONE;
    level_nxt = pressed;
    hold_a    = hold_r;
    gap_a     = gap_r;
    first_a   = first_r;

    if (cfg.long_enable && !level_r && pressed) begin
      hold_a = '0;
    end
    if (cfg.long_enable && level_r && pressed && (hold_r <= long_lim)) begin
      hold_a = kpc_pkg::sat_add(hold_r, cfg.tick_ms);
    end

    long_hit = cfg.long_enable && level_r && (hold_a > long_lim);
    if (long_hit) begin
      code   = kpc_pkg::CODE_LONG;
      hold_a = short_lim + 16'd1;
    end

    // After a long report the hold timer sits above the short limit, so no short release.
    if (level_r && !pressed && !long_hit && (hold_a <= short_lim)) begin
      if (!cfg.double_enable) begin
        code = kpc_pkg::CODE_SHORT;
      end else if (!first_r) begin
        first_a = 1'b1;
        gap_a   = '0;
      end else if (gap_r <= double_lim) begin
        code    = kpc_pkg::CODE_DOUBLE;
        first_a = 1'b0;
      end
    end

    hold_nxt  = hold_a;
    gap_nxt   = gap_a;
    first_nxt = first_a;
    if (first_a) begin
      gap_nxt = kpc_pkg::sat_add(gap_a, cfg.tick_ms);
      if (gap_nxt > double_lim) begin
        code      = kpc_pkg::CODE_SHORT;
        first_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 1'b0;
      hold_r  <= '0;
      gap_r   <= '0;
      first_r <= 1'b0;
    end else if (step) begin
      level_r <= level_nxt;
      hold_r  <= hold_nxt;
      gap_r   <= gap_nxt;
      first_r <= first_nxt;
    end
  end

  assign event_code = code;

endmodule

[test/press_event_check_pkg.sv]
// Scoreboard that predicts the event code of every scan tick and checks the block's result words.
`timescale 1ns / 1ps

package press_event_check_pkg;

  import kpc_pkg::*;

  class press_event_scoreboard;
    cfg_t             regs;
    bit               level_prev;
    bit [TIMER_W-1:0] hold_ms;
    bit [TIMER_W-1:0] gap_ms;
    bit               first_release;
    logic [1:0]       expected_codes[$];
    int               errors;

    function new();
      regs.tick_ms       = TICK_MS_RST;
      regs.long_ms       = LONG_MS_RST;
      regs.short_ms      = SHORT_MS_RST;
      regs.double_ms     = DOUBLE_MS_RST;
      regs.long_enable   = 1'b1;
      regs.double_enable = 1'b1;
      level_prev         = 1'b0;
      hold_ms            = '0;
      gap_ms             = '0;
      first_release      = 1'b0;
      errors             = 0;
    endfunction

    function void write_reg(logic [INDEX_W-1:0] index, logic [WDATA_W-1:0] data);
      case (index)
        REG_TICK_MS:       regs.tick_ms       = data[TICK_W-1:0];
        REG_LONG_MS:       regs.long_ms       = data[LIMIT_W-1:0];
        REG_SHORT_MS:      regs.short_ms      = data[LIMIT_W-1:0];
        REG_DOUBLE_MS:     regs.double_ms     = data[LIMIT_W-1:0];
        REG_LONG_ENABLE:   regs.long_enable   = data[0];
        REG_DOUBLE_ENABLE: regs.double_enable = data[0];
        default: ;
      endcase
    endfunction

    function bit [TIMER_W-1:0] advance(bit [TIMER_W-1:0] t);
      bit [TIMER_W:0] s;
      s = t + regs.tick_ms;
      return s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
    endfunction

    function void note_tick(bit pressed);
      bit         was_pressed;
      logic [1:0] code;
      was_pressed = level_prev;
      code        = CODE_NONE;
      level_prev  = pressed;
      if (regs.long_enable && !was_pressed && pressed) hold_ms = '0;
      if (regs.long_enable && was_pressed && pressed && hold_ms <= regs.long_ms)
        hold_ms = advance(hold_ms);
      if (regs.long_enable && was_pressed && hold_ms > regs.long_ms) begin
        code    = CODE_LONG;
        hold_ms = regs.short_ms + 16'd1;
      end
      if (was_pressed && !pressed && hold_ms <= regs.short_ms) begin
        if (!regs.double_enable) begin
          code = CODE_SHORT;
        end else if (!first_release) begin
          first_release = 1'b1;
          gap_ms        = '0;
        end else if (gap_ms <= regs.double_ms) begin
          code          = CODE_DOUBLE;
          first_release = 1'b0;
        end
      end
      if (first_release) begin
        gap_ms = advance(gap_ms);
        if (gap_ms > regs.double_ms) begin
          code          = CODE_SHORT;
          first_release = 1'b0;
        end
      end
      expected_codes.push_back(code);
    endfunction

    function void check_event(logic [1:0] code);
      logic [1:0] want;
      if (expected_codes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result word: event_code %0d.", code);
        return;
      end
      want = expected_codes.pop_front();
      if (code !== want) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch on event_code: expected %0d, got %0d.", want, code);
      end
    endfunction

    function int outstanding();
      return expected_codes.size();
    endfunction
  endclass

endpackage

[test/tb_top.sv]
// Top level of the key press classifier testbench: clock, reset, drivers and stimulus.
`timescale 1ns / 1ps

module tb_top;

  import kpc_pkg::*;
  import press_event_check_pkg::*;

  localparam logic [INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic               in_pressed     = 1'b0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic [1:0]         out_event_code;
  logic               cfg_valid      = 1'b0;
  logic               cfg_ready;
  logic [INDEX_W-1:0] cfg_index      = '0;
  logic [WDATA_W-1:0] cfg_wdata      = '0;

  press_event_scoreboard sb;
  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int ticks_sent    = 0;

  key_press_classifier_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pressed     (in_pressed),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_code (out_event_code),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_event(out_event_code);
      if (in_valid && in_ready) sb.note_tick(in_pressed);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_wdata);
    end
  end

  task automatic send_tick(bit level);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pressed <= level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic hold_release(int held, int released);
    repeat (held) send_tick(1'b1);
    repeat (released) send_tick(1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [INDEX_W-1:0] index, logic [WDATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Upper bits of the narrow registers carry random junk that must be ignored.
  task automatic set_config(int tick, int long_lim, int short_lim, int double_lim,
                            bit long_en, bit double_en);
    write_reg(REG_TICK_MS, {7'($urandom), tick[7:0]});
    write_reg(REG_LONG_MS, long_lim[14:0]);
    write_reg(REG_SHORT_MS, short_lim[14:0]);
    write_reg(REG_DOUBLE_MS, double_lim[14:0]);
    write_reg(REG_LONG_ENABLE, {14'($urandom), long_en});
    write_reg(REG_DOUBLE_ENABLE, {14'($urandom), double_en});
    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 15'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Mostly press and release runs sized around the current thresholds, some noise.
  task automatic press_pattern();
    int tick;
    int limit_ms;
    int held;
    int released;
    int kind;
    tick = sb.regs.tick_ms;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
      return;
    end
    case (kind)
      0, 1, 2, 3: limit_ms = $urandom_range(0, sb.regs.short_ms + tick);
      4, 5:       limit_ms = sb.regs.long_ms + $urandom_range(0, 3 * tick);
      default:    limit_ms = $urandom_range(0, sb.regs.long_ms + 2 * tick);
    endcase
    held = limit_ms / tick + 1;
    if (held > 150) held = 150;
    released = $urandom_range(0, sb.regs.double_ms + 2 * tick) / tick + 1;
    if (released > 150) released = 150;
    hold_release(held, released);
  endtask

  initial begin
    int target;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(100, 250, 150, 400, 1'b1, 1'b1);
    hold_release(2, 1);
    hold_release(2, 1);
    hold_release(1, 5);
    hold_release(5, 1);
    wait_drained();
    set_config(100, 250, 150, 400, 1'b1, 1'b0);
    hold_release(1, 1);
    wait_drained();
    set_config(100, 250, 150, 400, 1'b1, 1'b1);
    hold_release(1, 1);
    wait_drained();
    set_config(100, 250, 150, 400, 1'b1, 1'b0);
    hold_release(0, 4);
    wait_drained();
    set_config(100, 250, 150, 400, 1'b0, 1'b1);
    hold_release(3, 2);
    wait_drained();
    set_config(1, 0, 0, 0, 1'b1, 1'b1);
    hold_release(2, 2);
    wait_drained();
    set_config(255, 30000, 30000, 30000, 1'b1, 1'b1);
    hold_release(1, 2);

    for (int phase = 0; phase < 8; phase++) begin
      wait_drained();
      case (phase)
        0: set_config(20, 800, 200, 200, 1'b1, 1'b1);
        1: set_config($urandom_range(50, 255), $urandom_range(0, 3000),
                      $urandom_range(0, 1500), $urandom_range(0, 1500), 1'b1, 1'b1);
        2: set_config(1, 0, 0, 0, 1'b1, 1'b1);
        3: set_config(255, 30000, 30000, 30000, 1'b1, 1'b1);
        4: set_config($urandom_range(10, 80), 600, 200, 300, 1'b0, 1'b1);
        5: set_config($urandom_range(10, 80), 600, 200, 300, 1'b0, 1'b0);
        6: set_config(60, 100, 300, 250, 1'b1, 1'b1);
        default: set_config($urandom_range(1, 255), $urandom_range(0, 4000),
                            $urandom_range(0, 4000), $urandom_range(0, 4000),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      if (phase == 0) hold_requests++;
      target = ticks_sent + 190;
      while (ticks_sent < target) press_pattern();
    end

    wait_drained();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
